/* rtl/core/pdss_pkg.sv */
`default_nettype none

package pdss_pkg;

  localparam int unsigned ChanLimit = 16;

  localparam logic [7:0] DUTY_OFF  = 8'h00;
  localparam logic [7:0] DUTY_FULL = 8'hff;

  localparam logic [1:0] GROUP_SCHED = 2'd0;
  localparam logic [1:0] GROUP_FULL  = 2'd1;
  localparam logic [1:0] GROUP_OFF   = 2'd2;

  typedef struct packed {
    logic [3:0] channel;
    logic [7:0] duty;
  } in_t;

  typedef struct packed {
    logic [3:0] out_channel;
    logic [7:0] out_duty;
    logic [1:0] group;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [3:0] chan;
    logic [7:0] duty;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // order: scheduled duties ascending, then full on, then off
  function automatic logic [8:0] sort_key(input logic [7:0] duty);
    logic [8:0] key;
    if (duty == DUTY_OFF) begin
      key = 9'h100;
    end else begin
      key = {1'b0, duty};
    end
    return key;
  endfunction

  function automatic logic entry_less(input entry_t a, input entry_t b);
    return {sort_key(a.duty), a.chan} < {sort_key(b.duty), b.chan};
  endfunction

  function automatic logic [1:0] duty_group(input logic [7:0] duty);
    logic [1:0] grp;
    if (duty == DUTY_OFF) begin
      grp = GROUP_OFF;
    end else if (duty == DUTY_FULL) begin
      grp = GROUP_FULL;
    end else begin
      grp = GROUP_SCHED;
    end
    return grp;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pdss_sort_cell.sv */
`default_nettype none

module pdss_sort_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pdss_pkg::cell_ctrl_t ctrl_i,
  input  pdss_pkg::entry_t    new_entry_i,
  input  wire                 left_valid_i,
  input  wire                 left_lt_i,
  input  pdss_pkg::entry_t    left_entry_i,
  input  wire                 right_valid_i,
  input  pdss_pkg::entry_t    right_entry_i,
  output logic                valid_o,
  output logic                lt_o,
  output pdss_pkg::entry_t    entry_o
);

  logic             valid_q, valid_d;
  pdss_pkg::entry_t entry_q, entry_d;
  logic             own_lt;

  assign own_lt = valid_q && pdss_pkg::entry_less(entry_q, new_entry_i);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (own_lt) begin
        valid_d = valid_q;
      end else if (left_lt_i) begin
        valid_d = 1'b1;
        entry_d = new_entry_i;
      end else begin
        valid_d = left_valid_i;
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign lt_o    = own_lt;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/core/pwm_duty_schedule_sorter_unit.sv */
`default_nettype none

// Sorted duty schedule for a software PWM.
// Input: a word (channel, duty) is taken when start_i is high and busy_o low.
// Output: the rebuilt schedule, one word per channel on res_o, each shown
// for exactly one cycle with res_valid_o high; last marks the final word.
// Order: duties 1..254 ascending (ties by channel), then full-on channels,
// then off channels, each by channel index.
// Flow: the accepting edge writes the duty table and clears the chain; the
// insertion chain then takes one channel per cycle, followed by the
// shift-out of the chain, one result per cycle, registered onto res_o.
// busy_o stays high through both phases, so a new word is taken only after
// the previous schedule has been emitted.
// CHAN_COUNT is NUM_CHANNELS capped at 16; a channel at or above it
// changes nothing, and the unchanged schedule is still emitted.
// Reset sets every duty to zero and leaves the block idle; the receiver
// cannot stall, so results are never held.
module pwm_duty_schedule_sorter_unit #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  pdss_pkg::in_t   in_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output pdss_pkg::out_t  res_o
);

  localparam int unsigned ChanCount =
      (NUM_CHANNELS < pdss_pkg::ChanLimit) ? NUM_CHANNELS : pdss_pkg::ChanLimit;
  localparam int unsigned IdxW = $clog2(ChanCount);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ChanCount - 1);

  pdss_pkg::state_e    state_q, state_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [7:0]          duty_q [ChanCount];
  logic                accept;
  logic                chan_ok;
  pdss_pkg::cell_ctrl_t ctrl;
  pdss_pkg::entry_t    new_entry;
  logic                res_valid_q, res_valid_d;
  pdss_pkg::out_t      res_q, res_d;

  logic                cell_valid [ChanCount];
  logic                cell_lt    [ChanCount];
  pdss_pkg::entry_t    cell_entry [ChanCount];

  assign accept  = start_i && (state_q == pdss_pkg::ST_IDLE);
  assign chan_ok = {1'b0, in_i.channel} < 5'(ChanCount);

  assign new_entry.chan = 4'(cnt_q);
  assign new_entry.duty = duty_q[cnt_q];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl        = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      pdss_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.clear = 1'b1;
          cnt_d      = '0;
          state_d    = pdss_pkg::ST_LOAD;
        end
      end
      pdss_pkg::ST_LOAD: begin
        ctrl.insert = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = pdss_pkg::ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      pdss_pkg::ST_EMIT: begin
        ctrl.shift        = 1'b1;
        res_valid_d       = 1'b1;
        res_d.out_channel = cell_entry[0].chan;
        res_d.out_duty    = cell_entry[0].duty;
        res_d.group       = pdss_pkg::duty_group(cell_entry[0].duty);
        res_d.last        = (cnt_q == LastIdx);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = pdss_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = pdss_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdss_pkg::ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChanCount; i++) begin
        duty_q[i] <= pdss_pkg::DUTY_OFF;
      end
    end else if (accept && chan_ok) begin
      duty_q[in_i.channel[IdxW-1:0]] <= in_i.duty;
    end
  end

  for (genvar g = 0; g < ChanCount; g++) begin : g_cell
    logic             left_valid, left_lt, right_valid;
    pdss_pkg::entry_t left_entry, right_entry;

    if (g == 0) begin : g_head
      assign left_valid = 1'b0;
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_valid = cell_valid[g-1];
      assign left_lt    = cell_lt[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == ChanCount - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[g+1];
      assign right_entry = cell_entry[g+1];
    end

    pdss_sort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[g]),
      .lt_o          (cell_lt[g]),
      .entry_o       (cell_entry[g])
    );
  end

  assign busy_o      = (state_q != pdss_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* sim/pwm_duty_schedule_sorter_unit_tb.sv */
`timescale 1ns / 1ps

module pwm_duty_schedule_sorter_unit_tb;

  localparam int unsigned NCH = pdss_pkg::ChanLimit;
  localparam int unsigned RUN_LATENCY = 2 * NCH + 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 117;
  localparam int unsigned DIR_ROWS = 19;

  typedef struct packed {
    pdss_pkg::in_t  word;
    logic           typed;
    pdss_pkg::out_t first;
  } dir_row_t;

  typedef struct {
    int unsigned    run;
    pdss_pkg::out_t word;
  } first_chk_t;

  logic           clk_i;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  pdss_pkg::in_t  in_i = '0;
  logic           busy_o;
  logic           res_valid_o;
  pdss_pkg::out_t res_o;

  logic [7:0]     chan_duty [NCH];
  pdss_pkg::out_t sched_q [$];
  first_chk_t     first_chk_q [$];
  int unsigned words_sent = 0;
  int unsigned entries_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    {4'd0,  8'h00, 1'b1, {4'd0,  pdss_pkg::DUTY_OFF,  pdss_pkg::GROUP_OFF,   1'b0}},
    {4'd15, 8'hff, 1'b1, {4'd15, pdss_pkg::DUTY_FULL, pdss_pkg::GROUP_FULL,  1'b0}},
    {4'd0,  8'hff, 1'b1, {4'd0,  pdss_pkg::DUTY_FULL, pdss_pkg::GROUP_FULL,  1'b0}},
    {4'd7,  8'h01, 1'b1, {4'd7,  8'h01,               pdss_pkg::GROUP_SCHED, 1'b0}},
    {4'd8,  8'hfe, 1'b0, 15'd0},
    {4'd3,  8'h01, 1'b1, {4'd3,  8'h01,               pdss_pkg::GROUP_SCHED, 1'b0}},
    {4'd12, 8'h01, 1'b0, 15'd0},
    {4'd5,  8'h80, 1'b0, 15'd0},
    {4'd10, 8'h55, 1'b0, 15'd0},
    {4'd9,  8'haa, 1'b0, 15'd0},
    {4'd7,  8'h00, 1'b0, 15'd0},
    {4'd15, 8'h00, 1'b0, 15'd0},
    {4'd6,  8'h7f, 1'b0, 15'd0},
    {4'd11, 8'h02, 1'b0, 15'd0},
    {4'd13, 8'hfd, 1'b0, 15'd0},
    {4'd14, 8'h01, 1'b0, 15'd0},
    {4'd1,  8'hff, 1'b0, 15'd0},
    {4'd2,  8'hfe, 1'b0, 15'd0},
    {4'd4,  8'h01, 1'b0, 15'd0}
  };

  pwm_duty_schedule_sorter_unit #(
    .NUM_CHANNELS(NCH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // off channels sort after full-on ones, so rank them past 255
  function automatic void rebuild_schedule(pdss_pkg::in_t w);
    pdss_pkg::out_t e;
    int unsigned pos;
    int unsigned rank;
    chan_duty[w.channel] = w.duty;
    pos = 0;
    for (int unsigned k = 1; k <= 256; k++) begin
      for (int unsigned c = 0; c < NCH; c++) begin
        rank = (chan_duty[c] == pdss_pkg::DUTY_OFF) ? 256 : chan_duty[c];
        if (rank == k) begin
          e.out_channel = c[3:0];
          e.out_duty    = chan_duty[c];
          e.group       = (chan_duty[c] == pdss_pkg::DUTY_OFF)  ? pdss_pkg::GROUP_OFF :
                          (chan_duty[c] == pdss_pkg::DUTY_FULL) ? pdss_pkg::GROUP_FULL :
                          pdss_pkg::GROUP_SCHED;
          e.last        = (pos == NCH - 1);
          sched_q.push_back(e);
          pos++;
        end
      end
    end
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string tag, int unsigned want, int unsigned got);
    if (want != got)
      note_error($sformatf("entry %0d %s expected %0d got %0d",
                           entries_seen, tag, want, got));
  endtask

  task automatic send_word(pdss_pkg::in_t w, logic typed, pdss_pkg::out_t first);
    first_chk_t chk;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    if (typed) begin
      chk.run  = words_sent;
      chk.word = first;
      first_chk_q.push_back(chk);
    end
    rebuild_schedule(w);
    words_sent++;
  endtask

  // hold the sender until the whole schedule backlog has drained
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sched_q.size() != 0);
  endtask

  function automatic pdss_pkg::in_t random_word();
    pdss_pkg::in_t w;
    int unsigned pick;
    w.channel = 4'($urandom_range(NCH - 1));
    pick = $urandom_range(99);
    if (pick < 15)      w.duty = pdss_pkg::DUTY_OFF;
    else if (pick < 30) w.duty = pdss_pkg::DUTY_FULL;
    else if (pick < 40) w.duty = ($urandom_range(1) != 0) ? 8'h01 : 8'hfe;
    else if (pick < 55) w.duty = 8'($urandom_range(3, 1));
    else                w.duty = 8'($urandom_range(255));
    return w;
  endfunction

  always @(posedge clk_i) begin
    pdss_pkg::out_t want;
    first_chk_t     chk;
    if (rst_ni && res_valid_o) begin
      if (sched_q.size() == 0) begin
        note_error($sformatf("unexpected word ch %0d duty %0d grp %0d last %0d",
                             res_o.out_channel, res_o.out_duty, res_o.group, res_o.last));
      end else begin
        want = sched_q.pop_front();
        check_field("channel", want.out_channel, res_o.out_channel);
        check_field("duty", want.out_duty, res_o.out_duty);
        check_field("group", want.group, res_o.group);
        check_field("last", want.last, res_o.last);
      end
      if (first_chk_q.size() != 0 && entries_seen % NCH == 0 &&
          first_chk_q[0].run == entries_seen / NCH) begin
        chk  = first_chk_q.pop_front();
        want = chk.word;
        if (res_o != want)
          note_error($sformatf("run %0d head expected %h got %h",
                               entries_seen / NCH, want, res_o));
      end
      entries_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned pcts [3];
    pcts = '{23, 72, 0};
    for (int unsigned c = 0; c < NCH; c++) chan_duty[c] = pdss_pkg::DUTY_OFF;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < DIR_ROWS; r++)
      send_word(dir_tbl[r].word, dir_tbl[r].typed, dir_tbl[r].first);
    drain();

    for (int unsigned p = 0; p < 3; p++) begin
      idle_pct = pcts[p];
      for (int unsigned n = 0; n < PHASE_WORDS; n++)
        send_word(random_word(), 1'b0, '0);
      drain();
    end

    repeat (RUN_LATENCY) @(posedge clk_i);
    if (sched_q.size() != 0)
      note_error($sformatf("%0d schedule entries never arrived", sched_q.size()));
    if (first_chk_q.size() != 0)
      note_error($sformatf("%0d run heads never checked", first_chk_q.size()));

    $display("run covered %0d duty words (directed and three idle mixes), %0d entries",
             words_sent, entries_seen);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* pwm_duty_schedule_sorter_unit.f */
rtl/core/pdss_pkg.sv
rtl/core/pdss_sort_cell.sv
rtl/core/pwm_duty_schedule_sorter_unit.sv
sim/pwm_duty_schedule_sorter_unit_tb.sv
